@@ rtl/core/dtq_pkg.sv @@
// Shared constants, codes and types of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int DEADLINE_BITS   = 63;
  localparam int HANDLE_PORT_BITS = 16;
  localparam int STATUS_BITS     = 3;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_ADDR_BITS   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_BITS    = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [1:0] CMD_CANCEL   = 2'd1;
  localparam logic [1:0] CMD_POLL     = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_SCHEDULED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_CANCELLED  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_EXPIRED    = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_NONE_EXPIRED = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_EMIT_RD,
    S_EMIT_LD
  } dtq_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } tbl_ctrl_t;

  typedef struct packed {
    logic pend;
    logic entry_valid;
  } tbl_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/dtq_table.sv @@
// Entry table: deadline and handle memories with a registered read port and valid bits.
`timescale 1ns / 1ps
`default_nettype none

module dtq_table #(
  parameter int TABLE_DEPTH = dtq_pkg::TABLE_DEPTH_DEF,
  parameter int HANDLE_BITS = dtq_pkg::HANDLE_BITS_DEF,
  parameter int IW          = $clog2(TABLE_DEPTH)
) (
  input  wire                               clk,
  input  wire                               rst,
  input  dtq_pkg::tbl_ctrl_t                ctrl,
  input  wire  [IW-1:0]                     rd_addr,
  input  wire  [IW-1:0]                     wr_addr,
  input  wire  [dtq_pkg::DEADLINE_BITS-1:0] wr_deadline,
  input  wire  [HANDLE_BITS-1:0]            wr_handle,
  output dtq_pkg::tbl_rsp_t                 rsp,
  output logic [IW-1:0]                     rsp_idx,
  output logic [dtq_pkg::DEADLINE_BITS-1:0] rsp_deadline,
  output logic [HANDLE_BITS-1:0]            rsp_handle
);
  import dtq_pkg::*;

  logic [DEADLINE_BITS-1:0] mem_deadline [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0]   mem_handle   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   valid;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem_deadline[wr_addr] <= wr_deadline;
      mem_handle[wr_addr]   <= wr_handle;
    end
    if (ctrl.rd_en) begin
      rsp_deadline <= mem_deadline[rd_addr];
      rsp_handle   <= mem_handle[rd_addr];
      rsp_idx      <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= '0;
      rsp.pend        <= 1'b0;
      rsp.entry_valid <= 1'b0;
    end else begin
      rsp.pend <= ctrl.rd_en;
      if (ctrl.rd_en) begin
        rsp.entry_valid <= valid[rd_addr];
      end
      if (ctrl.set_valid) begin
        valid[wr_addr] <= 1'b1;
      end else if (ctrl.clr_valid) begin
        valid[wr_addr] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/deadline_timer_queue_unit.sv @@
// Top level of the deadline timer queue: command sequencer, result buffer and output register.
`timescale 1ns / 1ps
`default_nettype none

// Commands arrive on the input channel (in_valid/in_stall): schedule, cancel or poll.
// Each schedule, cancel or poll answers with one or more result beats on the output channel
// (out_valid/out_stall); last_result marks the final beat of a command.
// Every schedule, cancel or poll sweeps the entry memory once per pass through its single
// read port, one entry per cycle.
// Cancel takes one pass.
// Schedule takes one pass plus one more per deadline bump.
// Poll takes one pass per expired task it reports (up to MAX_RESULTS) plus a final one;
// its results are delivered once the last pass ends.
// One command is worked on at a time; in_stall is high from acceptance until the
// last result is loaded into the output register, so a new command can be taken
// while that final beat still waits on the receiver.
// A stall on the output holds the current beat and pauses the delivery of the rest.
// Command code 3 is accepted and dropped without any result.
// Reset clears all valid bits, so the table starts empty; no clearing pass is needed.

module deadline_timer_queue_unit #(
  parameter int TABLE_DEPTH = dtq_pkg::TABLE_DEPTH_DEF,
  parameter int HANDLE_BITS = dtq_pkg::HANDLE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [1:0]                           command,
  input  wire  [dtq_pkg::DEADLINE_BITS-1:0]    deadline_or_id,
  input  wire  [dtq_pkg::DEADLINE_BITS-1:0]    current_time,
  input  wire  [dtq_pkg::HANDLE_PORT_BITS-1:0] task_handle,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [dtq_pkg::STATUS_BITS-1:0]      status,
  output logic [dtq_pkg::DEADLINE_BITS-1:0]    task_id,
  output logic [dtq_pkg::HANDLE_PORT_BITS-1:0] expired_handle,
  output logic [dtq_pkg::DEADLINE_BITS-1:0]    next_deadline,
  output logic                                 next_valid,
  output logic                                 last_result
);
  import dtq_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
  localparam logic [RES_CNT_BITS-1:0] MAX_CNT = RES_CNT_BITS'(MAX_RESULTS);

  dtq_state_t state, state_next;

  logic [1:0]               cmd;
  logic [DEADLINE_BITS-1:0] key;
  logic [DEADLINE_BITS-1:0] now;
  logic [HANDLE_BITS-1:0]   handle;

  logic [IW-1:0] iss_addr;
  logic          iss_done;

  logic                     free_found, match_found, min_found;
  logic [IW-1:0]            free_idx, match_idx, min_idx;
  logic [DEADLINE_BITS-1:0] min_d;
  logic [HANDLE_BITS-1:0]   min_h;

  logic [RES_CNT_BITS-1:0]  cnt;
  logic [RES_CNT_BITS-1:0]  emit_k;
  logic [DEADLINE_BITS-1:0] nd;
  logic                     nv;

  logic [STATUS_BITS-1:0]   buf_status [MAX_RESULTS];
  logic [DEADLINE_BITS-1:0] buf_id     [MAX_RESULTS];
  logic [HANDLE_BITS-1:0]   buf_handle [MAX_RESULTS];
  logic [STATUS_BITS-1:0]   rd_status;
  logic [DEADLINE_BITS-1:0] rd_id;
  logic [HANDLE_BITS-1:0]   rd_handle;

  tbl_ctrl_t                tctrl;
  tbl_rsp_t                 trsp;
  logic [IW-1:0]            t_wr_addr;
  logic [IW-1:0]            t_idx;
  logic [DEADLINE_BITS-1:0] t_deadline;
  logic [HANDLE_BITS-1:0]   t_handle;

  logic                     accept, out_free, emit_last;
  logic                     sched_retry, poll_more, restart, push;
  logic [STATUS_BITS-1:0]   push_status;
  logic [DEADLINE_BITS-1:0] push_id;
  logic [HANDLE_BITS-1:0]   push_handle;
  logic [DEADLINE_BITS-1:0] fin_nd;
  logic                     fin_nv;
  logic                     e_valid, e_match, e_excl;

  dtq_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .HANDLE_BITS(HANDLE_BITS),
    .IW         (IW)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (tctrl),
    .rd_addr     (iss_addr),
    .wr_addr     (t_wr_addr),
    .wr_deadline (key),
    .wr_handle   (handle),
    .rsp         (trsp),
    .rsp_idx     (t_idx),
    .rsp_deadline(t_deadline),
    .rsp_handle  (t_handle)
  );

  assign accept    = (state == S_IDLE) && in_valid;
  assign out_free  = !out_valid || !out_stall;
  assign emit_last = ((emit_k + 1'b1) == cnt);

  assign e_valid = trsp.pend && trsp.entry_valid;
  assign e_match = e_valid && (t_deadline == key);
  assign e_excl  = (cmd == CMD_CANCEL) && (t_deadline == key);

  assign sched_retry = free_found && match_found;
  assign poll_more   = min_found && (min_d <= now) && (cnt < MAX_CNT);

  always_comb begin
    restart     = 1'b0;
    push        = 1'b0;
    push_status = ST_NONE_EXPIRED;
    push_id     = '0;
    push_handle = '0;
    fin_nd      = min_found ? min_d : '0;
    fin_nv      = min_found;
    t_wr_addr   = min_idx;
    case (cmd)
      CMD_SCHEDULE: begin
        t_wr_addr = free_idx;
        if (!free_found) begin
          push        = 1'b1;
          push_status = ST_FULL;
        end else if (match_found) begin
          restart = 1'b1;
        end else begin
          push        = 1'b1;
          push_status = ST_SCHEDULED;
          push_id     = key;
          fin_nd      = (min_found && (min_d < key)) ? min_d : key;
          fin_nv      = 1'b1;
        end
      end
      CMD_CANCEL: begin
        t_wr_addr   = match_idx;
        push        = 1'b1;
        push_status = match_found ? ST_CANCELLED : ST_NOT_FOUND;
        push_id     = key;
      end
      CMD_POLL: begin
        if (poll_more) begin
          restart     = 1'b1;
          push        = 1'b1;
          push_status = ST_EXPIRED;
          push_id     = min_d;
          push_handle = min_h;
        end else if (cnt == '0) begin
          push = 1'b1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && (command inside {CMD_SCHEDULE, CMD_CANCEL, CMD_POLL})) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (trsp.pend && (t_idx == LAST_IDX)) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = restart ? S_SCAN : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          state_next = emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall        = (state != S_IDLE);
    tctrl.rd_en     = (state == S_SCAN) && !iss_done;
    tctrl.wr_en     = 1'b0;
    tctrl.set_valid = 1'b0;
    tctrl.clr_valid = 1'b0;
    if (state == S_SCAN_END) begin
      case (cmd)
        CMD_SCHEDULE: begin
          tctrl.wr_en     = free_found && !match_found;
          tctrl.set_valid = free_found && !match_found;
        end
        CMD_CANCEL: begin
          tctrl.clr_valid = match_found;
        end
        CMD_POLL: begin
          tctrl.clr_valid = poll_more;
        end
        default: begin
          tctrl.wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_addr    <= '0;
      iss_done    <= 1'b0;
      free_found  <= 1'b0;
      match_found <= 1'b0;
      min_found   <= 1'b0;
      cnt         <= '0;
      emit_k      <= '0;
    end else begin
      if (accept || (state == S_SCAN_END && restart)) begin
        iss_addr    <= '0;
        iss_done    <= 1'b0;
        free_found  <= 1'b0;
        match_found <= 1'b0;
        min_found   <= 1'b0;
      end else if (state == S_SCAN) begin
        if (tctrl.rd_en) begin
          if (iss_addr == LAST_IDX) begin
            iss_done <= 1'b1;
          end else begin
            iss_addr <= iss_addr + 1'b1;
          end
        end
        if (trsp.pend && !trsp.entry_valid && !free_found) begin
          free_found <= 1'b1;
        end
        if (e_match) begin
          match_found <= 1'b1;
        end
        if (e_valid && !e_excl && (!min_found || (t_deadline < min_d))) begin
          min_found <= 1'b1;
        end
      end
      if (accept) begin
        cnt <= '0;
      end else if (state == S_SCAN_END && push) begin
        cnt <= cnt + 1'b1;
      end
      if (state == S_SCAN_END) begin
        emit_k <= '0;
      end else if (state == S_EMIT_LD && out_free) begin
        emit_k <= emit_k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= command;
      key    <= deadline_or_id;
      now    <= current_time;
      handle <= HANDLE_BITS'(task_handle);
    end else if (state == S_SCAN_END && cmd == CMD_SCHEDULE && sched_retry) begin
      key <= key + 1'b1;
    end
    if (state == S_SCAN) begin
      if (trsp.pend && !trsp.entry_valid && !free_found) begin
        free_idx <= t_idx;
      end
      if (e_match) begin
        match_idx <= t_idx;
      end
      if (e_valid && !e_excl && (!min_found || (t_deadline < min_d))) begin
        min_d   <= t_deadline;
        min_h   <= t_handle;
        min_idx <= t_idx;
      end
    end
    if (state == S_SCAN_END && !restart) begin
      nd <= fin_nd;
      nv <= fin_nv;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN_END && push) begin
      buf_status[cnt[RES_ADDR_BITS-1:0]] <= push_status;
      buf_id[cnt[RES_ADDR_BITS-1:0]]     <= push_id;
      buf_handle[cnt[RES_ADDR_BITS-1:0]] <= push_handle;
    end
    if (state == S_EMIT_RD) begin
      rd_status <= buf_status[emit_k[RES_ADDR_BITS-1:0]];
      rd_id     <= buf_id[emit_k[RES_ADDR_BITS-1:0]];
      rd_handle <= buf_handle[emit_k[RES_ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT_LD && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT_LD && out_free) begin
      status         <= rd_status;
      task_id        <= rd_id;
      expired_handle <= HANDLE_PORT_BITS'(rd_handle);
      next_deadline  <= nd;
      next_valid     <= nv;
      last_result    <= emit_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= MAX_CNT)
    else $error("result count exceeds the buffer depth");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD) |-> (emit_k < cnt))
    else $error("result read beyond the filled part of the buffer");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_result) |=> (out_valid || (state != S_IDLE)))
    else $error("command finished before its last beat was delivered");

  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (!tctrl.wr_en && !tctrl.set_valid && !tctrl.clr_valid))
    else $error("table modified during a scan pass");

endmodule

`default_nettype wire

@@ dv/deadline_timer_queue_unit_tb.sv @@
// Self-checking testbench of the deadline timer queue: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module deadline_timer_queue_unit_tb;
  import dtq_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic [DEADLINE_BITS-1:0] MAX_DEADLINE = {DEADLINE_BITS{1'b1}};
  localparam int RANDOM_ITEMS = 146;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 4 * TABLE_DEPTH;

  typedef struct packed {
    logic [STATUS_BITS-1:0]      status;
    logic [DEADLINE_BITS-1:0]    task_id;
    logic [HANDLE_PORT_BITS-1:0] handle;
    logic [DEADLINE_BITS-1:0]    next_deadline;
    logic                        next_valid;
    logic                        last;
  } timer_result_t;

  typedef struct {
    logic [1:0]                  cmd;
    logic [DEADLINE_BITS-1:0]    key;
    logic [DEADLINE_BITS-1:0]    now;
    logic [HANDLE_PORT_BITS-1:0] hnd;
    int                          reps;
    bit                          typed;
    logic [STATUS_BITS-1:0]      st;
    logic [DEADLINE_BITS-1:0]    id;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  command = CMD_SCHEDULE;
  logic [DEADLINE_BITS-1:0]    deadline_or_id = '0;
  logic [DEADLINE_BITS-1:0]    current_time = '0;
  logic [HANDLE_PORT_BITS-1:0] task_handle = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [STATUS_BITS-1:0]      status;
  logic [DEADLINE_BITS-1:0]    task_id;
  logic [HANDLE_PORT_BITS-1:0] expired_handle;
  logic [DEADLINE_BITS-1:0]    next_deadline;
  logic                        next_valid;
  logic                        last_result;

  logic [DEADLINE_BITS-1:0]    pend_deadline [TABLE_DEPTH];
  logic [HANDLE_PORT_BITS-1:0] pend_handle [TABLE_DEPTH];
  bit                          pend_valid [TABLE_DEPTH];

  timer_result_t step_results[$];
  timer_result_t expected_results[$];
  stim_row_t     directed_rows[$];

  int idle_mode = 0;
  int error_count = 0;
  int cycle_count = 0;
  int beat_count = 0;
  int sched_count = 0;
  int cancel_count = 0;
  int poll_count = 0;
  int dropped_count = 0;
  int full_count = 0;
  int bump_count = 0;
  int widest_poll = 0;
  logic [DEADLINE_BITS-1:0] time_base = 63'd5000;

  deadline_timer_queue_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .deadline_or_id (deadline_or_id),
    .current_time   (current_time),
    .task_handle    (task_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .task_id        (task_id),
    .expired_handle (expired_handle),
    .next_deadline  (next_deadline),
    .next_valid     (next_valid),
    .last_result    (last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DEADLINE_BITS-1:0] rand_deadline();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[DEADLINE_BITS-1:0];
  endfunction

  function automatic int find_pending(logic [DEADLINE_BITS-1:0] d);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (pend_valid[i] && pend_deadline[i] == d) return i;
    end
    return -1;
  endfunction

  function automatic int find_earliest();
    int best;
    best = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (pend_valid[i] && (best < 0 || pend_deadline[i] < pend_deadline[best])) best = i;
    end
    return best;
  endfunction

  function automatic int pending_count();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) n += pend_valid[i];
    return n;
  endfunction

  function automatic logic [DEADLINE_BITS-1:0] pick_pending();
    int n;
    int pick;
    n = pending_count();
    pick = $urandom_range(n - 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (pend_valid[i]) begin
        if (pick == 0) return pend_deadline[i];
        pick--;
      end
    end
    return '0;
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] cmd, logic [DEADLINE_BITS-1:0] key,
                                       logic [DEADLINE_BITS-1:0] now,
                                       logic [HANDLE_PORT_BITS-1:0] hnd, int reps, bit typed,
                                       logic [STATUS_BITS-1:0] st,
                                       logic [DEADLINE_BITS-1:0] id);
    stim_row_t r;
    r.cmd = cmd;
    r.key = key;
    r.now = now;
    r.hnd = hnd;
    r.reps = reps;
    r.typed = typed;
    r.st = st;
    r.id = id;
    return r;
  endfunction

  // Updates the pending table for one command and leaves its results in step_results.
  task automatic predict_timer_cmd(input logic [1:0] cmd, input logic [DEADLINE_BITS-1:0] key,
                                   input logic [DEADLINE_BITS-1:0] now,
                                   input logic [HANDLE_PORT_BITS-1:0] hnd);
    timer_result_t r;
    int slot;
    int e;
    int bumps;
    logic [DEADLINE_BITS-1:0] d;
    logic [DEADLINE_BITS-1:0] nd;
    logic nv;
    step_results.delete();
    r = '0;
    case (cmd)
      CMD_SCHEDULE: begin
        sched_count++;
        slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!pend_valid[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          full_count++;
          r.status = ST_FULL;
        end else begin
          d = key;
          bumps = 0;
          while (bumps <= TABLE_DEPTH && find_pending(d) >= 0) begin
            d = d + 1'b1;
            bumps++;
          end
          bump_count += bumps;
          pend_deadline[slot] = d;
          pend_handle[slot] = hnd;
          pend_valid[slot] = 1'b1;
          r.status = ST_SCHEDULED;
          r.task_id = d;
        end
        step_results.push_back(r);
      end
      CMD_CANCEL: begin
        cancel_count++;
        e = find_pending(key);
        if (e >= 0) begin
          pend_valid[e] = 1'b0;
          r.status = ST_CANCELLED;
        end else begin
          r.status = ST_NOT_FOUND;
        end
        r.task_id = key;
        step_results.push_back(r);
      end
      CMD_POLL: begin
        poll_count++;
        while (step_results.size() < MAX_RESULTS) begin
          e = find_earliest();
          if (e < 0 || pend_deadline[e] > now) break;
          r.status = ST_EXPIRED;
          r.task_id = pend_deadline[e];
          r.handle = pend_handle[e];
          step_results.push_back(r);
          pend_valid[e] = 1'b0;
        end
        if (step_results.size() > widest_poll) widest_poll = step_results.size();
        if (step_results.size() == 0) begin
          r.status = ST_NONE_EXPIRED;
          step_results.push_back(r);
        end
      end
      default: begin
        dropped_count++;
        return;
      end
    endcase
    e = find_earliest();
    nd = (e >= 0) ? pend_deadline[e] : '0;
    nv = (e >= 0);
    for (int k = 0; k < step_results.size(); k++) begin
      r = step_results[k];
      r.next_deadline = nd;
      r.next_valid = nv;
      r.last = (k == step_results.size() - 1);
      step_results[k] = r;
    end
  endtask

  task automatic drive_cmd(input logic [1:0] cmd, input logic [DEADLINE_BITS-1:0] key,
                           input logic [DEADLINE_BITS-1:0] now,
                           input logic [HANDLE_PORT_BITS-1:0] hnd, input bit typed,
                           input logic [STATUS_BITS-1:0] st, input logic [DEADLINE_BITS-1:0] id);
    int gap_pct;
    timer_result_t r;
    gap_pct = (idle_mode == 0) ? 34 : (idle_mode == 1) ? 78 : 0;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    command <= cmd;
    deadline_or_id <= key;
    current_time <= now;
    task_handle <= hnd;
    do @(posedge clk); while (in_stall);
    predict_timer_cmd(cmd, key, now, hnd);
    if (typed && step_results.size() != 0) begin
      r = step_results[0];
      r.status = st;
      r.task_id = id;
      step_results[0] = r;
    end
    foreach (step_results[k]) expected_results.push_back(step_results[k]);
  endtask

  // Mostly well-formed traffic around a moving time base, with some far-off values and noise.
  task automatic random_cmd(output bit counted);
    int pick;
    int sub;
    logic [1:0] cmd;
    logic [DEADLINE_BITS-1:0] key;
    logic [DEADLINE_BITS-1:0] now;
    logic [HANDLE_PORT_BITS-1:0] hnd;
    pick = $urandom_range(99);
    sub = $urandom_range(99);
    key = rand_deadline();
    now = rand_deadline();
    hnd = HANDLE_PORT_BITS'($urandom);
    counted = 1'b1;
    if (pick < 42) begin
      cmd = CMD_SCHEDULE;
      if (sub < 60) key = time_base + 63'($urandom_range(60));
      else if (sub < 78 && pending_count() != 0) key = pick_pending();
      else if (sub < 88) key = MAX_DEADLINE - 63'($urandom_range(3));
    end else if (pick < 62) begin
      cmd = CMD_CANCEL;
      if (sub < 70 && pending_count() != 0) key = pick_pending();
      else if (sub < 85) key = time_base + 63'($urandom_range(60));
    end else if (pick < 95) begin
      cmd = CMD_POLL;
      time_base = time_base + 63'($urandom_range(40));
      if (sub < 85) now = time_base;
      else if (sub < 92) now = MAX_DEADLINE;
    end else begin
      cmd = CMD_NOP;
      counted = 1'b0;
    end
    drive_cmd(cmd, key, now, hnd, 1'b0, ST_SCHEDULED, '0);
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < ((idle_mode == 0) ? 78 : (idle_mode == 1) ? 34 : 0));
  end

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && out_valid && !out_stall) begin
      beat_count++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("Unexpected beat: status=%0d id=%0h handle=%0h", status, task_id,
                   expired_handle);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || task_id !== want.task_id ||
            expired_handle !== want.handle || next_deadline !== want.next_deadline ||
            next_valid !== want.next_valid || last_result !== want.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display("Mismatch at cycle %0d:", cycle_count);
            $display("  expected status=%0d id=%0h handle=%0h next=%0h nv=%0b last=%0b",
                     want.status, want.task_id, want.handle, want.next_deadline,
                     want.next_valid, want.last);
            $display("  actual   status=%0d id=%0h handle=%0h next=%0h nv=%0b last=%0b",
                     status, task_id, expired_handle, next_deadline, next_valid,
                     last_result);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats still expected.", cycle_count,
               expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int done_items;
    bit counted;
    stim_row_t row;
    for (int i = 0; i < TABLE_DEPTH; i++) pend_valid[i] = 1'b0;

    // The table starts empty, so the first schedules land in entries 0 upward.
    directed_rows.push_back(mk_row(CMD_POLL, '0, '0, '0, 1, 1, ST_NONE_EXPIRED, '0));
    directed_rows.push_back(mk_row(CMD_CANCEL, 63'd5, '0, '0, 1, 1, ST_NOT_FOUND, 63'd5));
    directed_rows.push_back(mk_row(CMD_SCHEDULE, '0, '0, 16'h0000, 1, 1, ST_SCHEDULED, '0));
    directed_rows.push_back(mk_row(CMD_SCHEDULE, '0, '0, 16'hFFFF, 1, 1, ST_SCHEDULED, 63'd1));
    directed_rows.push_back(mk_row(CMD_SCHEDULE, MAX_DEADLINE, '0, 16'h8001, 1, 1,
                                   ST_SCHEDULED, MAX_DEADLINE));
    directed_rows.push_back(mk_row(CMD_SCHEDULE, MAX_DEADLINE, MAX_DEADLINE, 16'h7FFE, 1, 1,
                                   ST_SCHEDULED, 63'd2));
    directed_rows.push_back(mk_row(CMD_CANCEL, 63'd1, '0, '0, 1, 1, ST_CANCELLED, 63'd1));
    directed_rows.push_back(mk_row(CMD_SCHEDULE, 63'd1, '0, 16'h5555, 1, 1, ST_SCHEDULED,
                                   63'd1));
    directed_rows.push_back(mk_row(CMD_NOP, MAX_DEADLINE, MAX_DEADLINE, 16'hFFFF, 1, 0,
                                   ST_SCHEDULED, '0));
    directed_rows.push_back(mk_row(CMD_SCHEDULE, 63'd1000, '0, 16'h0A00, 12, 0,
                                   ST_SCHEDULED, '0));
    directed_rows.push_back(mk_row(CMD_SCHEDULE, 63'd7, '0, 16'h1234, 1, 1, ST_FULL, '0));
    directed_rows.push_back(mk_row(CMD_POLL, '0, MAX_DEADLINE, '0, 1, 0, ST_SCHEDULED, '0));
    directed_rows.push_back(mk_row(CMD_POLL, MAX_DEADLINE, '0, '0, 1, 1, ST_NONE_EXPIRED,
                                   '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      for (int j = 0; j < row.reps; j++)
        drive_cmd(row.cmd, row.key, row.now, row.hnd + 16'(j), row.typed, row.st, row.id);
    end

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      idle_mode = (done_items * 3) / RANDOM_ITEMS;
      random_cmd(counted);
      if (counted) done_items++;
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d schedules, %0d cancels, %0d polls and %0d dropped commands; %0d beats.",
             sched_count, cancel_count, poll_count, dropped_count, beat_count);
    $display("Table full %0d times, %0d deadline bumps, widest poll %0d expired tasks.",
             full_count, bump_count, widest_poll);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/dtq_pkg.sv
rtl/core/dtq_table.sv
rtl/core/deadline_timer_queue_unit.sv
dv/deadline_timer_queue_unit_tb.sv
